// ----- sv/hfd_pkg.sv -----
// Shared types, constants and band lookup for the howling feedback detector.
// No dependencies; every other file of the block imports this package.
package hfd_pkg;

    localparam int NUM_BANDS  = 32;
    localparam int BAND_W     = 5;
    localparam int BIN_W      = 9;
    localparam int RUN_W      = 7;
    localparam int HOLD_W     = 10;
    localparam int POWER_W    = 32;
    localparam int SUM_W      = 40;
    localparam int PEAK3_W    = 34;
    localparam int ENERGY_W   = 42;
    localparam int GAIN_W     = 16;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_TRIGGER_RUN   = 3'd0;
    localparam logic [2:0] REG_RETRIGGER_RUN = 3'd1;
    localparam logic [2:0] REG_HOLD_FRAMES   = 3'd2;
    localparam logic [2:0] REG_FAST_RUN      = 3'd3;
    localparam logic [2:0] REG_COUNT_CAP     = 3'd4;
    localparam logic [2:0] REG_FIRST_BAND    = 3'd5;

    // Register reset values
    localparam logic [RUN_W-1:0]  RST_TRIGGER_RUN   = 7'd26;
    localparam logic [RUN_W-1:0]  RST_RETRIGGER_RUN = 7'd10;
    localparam logic [HOLD_W-1:0] RST_HOLD_FRAMES   = 10'd300;
    localparam logic [RUN_W-1:0]  RST_FAST_RUN      = 7'd4;
    localparam logic [RUN_W-1:0]  RST_COUNT_CAP     = 7'd100;
    localparam logic [BAND_W-1:0] RST_FIRST_BAND    = 5'd8;

    localparam logic [BIN_W-1:0] BIN_MAX = 9'd511;

    // Band edges in bins; howl band b spans EDGE[b+1] .. EDGE[b+2]-1
    localparam logic [BIN_W-1:0] EDGE [0:NUM_BANDS+1] = '{
        9'd0,   9'd2,   9'd4,   9'd6,   9'd8,   9'd10,  9'd12,  9'd15,  9'd18,
        9'd21,  9'd24,  9'd28,  9'd32,  9'd36,  9'd41,  9'd47,  9'd53,  9'd60,
        9'd68,  9'd77,  9'd87,  9'd98,  9'd110, 9'd124, 9'd140, 9'd157, 9'd176,
        9'd198, 9'd223, 9'd251, 9'd282, 9'd317, 9'd356, 9'd400};

    typedef struct packed {
        logic [RUN_W-1:0]  trigger_run;
        logic [RUN_W-1:0]  retrigger_run;
        logic [HOLD_W-1:0] hold_frames;
        logic [RUN_W-1:0]  fast_run;
        logic [RUN_W-1:0]  count_cap;
        logic [BAND_W-1:0] first_band;
    } hfd_cfg_t;

    // Position of one bin within the band table
    typedef struct packed {
        logic              in_band;
        logic              is_lo;
        logic              is_end;
        logic [BAND_W-1:0] band;
    } hfd_bin_t;

    // One band-end or frame-end job handed from front to back
    typedef struct packed {
        logic                eval;
        logic                last;
        logic [BAND_W-1:0]   band;
        logic [BIN_W-1:0]    peak_bin;
        logic [SUM_W-1:0]    sum;
        logic [POWER_W-1:0]  peak;
        logic [POWER_W-1:0]  left;
        logic [POWER_W-1:0]  right;
        logic [ENERGY_W-1:0] energy;
        logic [GAIN_W-1:0]   gain;
        logic [RUN_W-1:0]    trigger_run;
        logic [RUN_W-1:0]    retrigger_run;
    } hfd_job_t;

    // Locate a bin: bands are disjoint, so at most one match
    function automatic hfd_bin_t bin_info(input logic [BIN_W-1:0] idx);
        hfd_bin_t info;
        info = '0;
        for (int b = 0; b < NUM_BANDS; b++)
        begin
            if (idx >= EDGE[b+1] && idx < EDGE[b+2])
            begin
                info.in_band = 1'b1;
                info.is_lo   = (idx == EDGE[b+1]);
                info.is_end  = (idx == EDGE[b+2] - 9'd1);
                info.band    = BAND_W'(b);
            end
        end
        return info;
    endfunction

endpackage

// ----- sv/howling_feedback_detector_core.sv -----
// Howling feedback detector: bins enter one per cycle; the job pushed with
// last_bin passes the queue, back stages s1 and s2, and the output register.
// Throughput: one bin per cycle, sustained; the front stalls only on a full
// four-entry job queue, which fills only while a result waits at the output.
// Reset (rst_n, async, active low) clears counters, peak history, hold timer
// and pipeline; configuration registers return to their defaults.
module howling_feedback_detector_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hfd_pkg::ADDR_W-1:0]     paddr,
    input  logic [hfd_pkg::DATA_W-1:0]     pwdata,
    output logic [hfd_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [hfd_pkg::POWER_W-1:0]    bin_power,
    input  logic [hfd_pkg::ENERGY_W-1:0]   frame_energy,
    input  logic [hfd_pkg::GAIN_W-1:0]     band_gain,
    input  logic                           last_bin,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           howl_active,
    output logic                           confirmed,
    output logic [hfd_pkg::HOLD_W-1:0]     hold_left
);
    import hfd_pkg::*;

    hfd_cfg_t   cfg_reg;
    logic [2:0] reg_index;
    logic       cfg_write;
    logic       accept, push, pop, empty, full;
    hfd_job_t   push_job, head_job;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_run   <= RST_TRIGGER_RUN;
            cfg_reg.retrigger_run <= RST_RETRIGGER_RUN;
            cfg_reg.hold_frames   <= RST_HOLD_FRAMES;
            cfg_reg.fast_run      <= RST_FAST_RUN;
            cfg_reg.count_cap     <= RST_COUNT_CAP;
            cfg_reg.first_band    <= RST_FIRST_BAND;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_TRIGGER_RUN:   cfg_reg.trigger_run   <= pwdata[RUN_W-1:0];
                REG_RETRIGGER_RUN: cfg_reg.retrigger_run <= pwdata[RUN_W-1:0];
                REG_HOLD_FRAMES:   cfg_reg.hold_frames   <= pwdata[HOLD_W-1:0];
                REG_FAST_RUN:      cfg_reg.fast_run      <= pwdata[RUN_W-1:0];
                REG_COUNT_CAP:     cfg_reg.count_cap     <= pwdata[RUN_W-1:0];
                REG_FIRST_BAND:    cfg_reg.first_band    <= pwdata[BAND_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        case (reg_index)
            REG_TRIGGER_RUN:   prdata = DATA_W'(cfg_reg.trigger_run);
            REG_RETRIGGER_RUN: prdata = DATA_W'(cfg_reg.retrigger_run);
            REG_HOLD_FRAMES:   prdata = DATA_W'(cfg_reg.hold_frames);
            REG_FAST_RUN:      prdata = DATA_W'(cfg_reg.fast_run);
            REG_COUNT_CAP:     prdata = DATA_W'(cfg_reg.count_cap);
            REG_FIRST_BAND:    prdata = DATA_W'(cfg_reg.first_band);
            default:           prdata = '0;
        endcase
    end

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    hfd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .accept       (accept),
        .bin_power    (bin_power),
        .frame_energy (frame_energy),
        .band_gain    (band_gain),
        .last_bin     (last_bin),
        .push         (push),
        .job          (push_job)
    );

    hfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty),
        .full     (full)
    );

    hfd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head_job    (head_job),
        .empty       (empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .howl_active (howl_active),
        .confirmed   (confirmed),
        .hold_left   (hold_left)
    );

endmodule

// ----- sv/hfd_front.sv -----
// Front end: accepts bin transactions, tracks band peak and sum, emits jobs.
// Depends on hfd_pkg.
module hfd_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hfd_pkg::hfd_cfg_t              cfg,
    input  logic                           accept,
    input  logic [hfd_pkg::POWER_W-1:0]    bin_power,
    input  logic [hfd_pkg::ENERGY_W-1:0]   frame_energy,
    input  logic [hfd_pkg::GAIN_W-1:0]     band_gain,
    input  logic                           last_bin,
    output logic                           push,
    output hfd_pkg::hfd_job_t              job
);
    import hfd_pkg::*;

    logic [BIN_W-1:0]   bin_index_reg, bin_index_next;
    hfd_bin_t           info_reg, info_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [POWER_W-1:0] peak_reg, peak_next;
    logic [BIN_W-1:0]   peak_bin_reg, peak_bin_next;
    logic [POWER_W-1:0] left_reg, left_next;
    logic [POWER_W-1:0] right_reg, right_next;
    logic [POWER_W-1:0] prev_reg;
    logic [RUN_W-1:0]   trig_reg, trig_next;
    logic [RUN_W-1:0]   retrig_reg, retrig_next;

    logic [SUM_W-1:0]   sum_base;
    logic [POWER_W-1:0] peak_base, left_base, right_base;
    logic [BIN_W-1:0]   peak_bin_base;
    logic               eval;

    // Advance the bin counter and look up the next bin's band position
    always_comb
    begin
        if (last_bin)
            bin_index_next = '0;
        else if (bin_index_reg != BIN_MAX)
            bin_index_next = bin_index_reg + 9'd1;
        else
            bin_index_next = BIN_MAX;
        info_next = bin_info(bin_index_next);
    end

    // Latch run thresholds at the first bin of each frame
    always_comb
    begin
        trig_next   = trig_reg;
        retrig_next = retrig_reg;
        if (bin_index_reg == '0)
        begin
            trig_next   = cfg.trigger_run;
            retrig_next = cfg.retrigger_run;
        end
    end

    // Track the first strict maximum of the band and its neighbors
    always_comb
    begin
        if (info_reg.is_lo)
        begin
            sum_base      = '0;
            peak_base     = '0;
            peak_bin_base = bin_index_reg;
            left_base     = '0;
            right_base    = '0;
        end
        else
        begin
            sum_base      = sum_reg;
            peak_base     = peak_reg;
            peak_bin_base = peak_bin_reg;
            left_base     = left_reg;
            right_base    = right_reg;
        end
        sum_next      = sum_base + SUM_W'(bin_power);
        peak_next     = peak_base;
        peak_bin_next = peak_bin_base;
        left_next     = left_base;
        right_next    = right_base;
        if (bin_power > peak_base)
        begin
            peak_next     = bin_power;
            peak_bin_next = bin_index_reg;
            left_next     = info_reg.is_lo ? '0 : prev_reg;
            right_next    = '0;
        end
        else if ({1'b0, bin_index_reg} == {1'b0, peak_bin_base} + 10'd1)
        begin
            right_next = bin_power;
        end
    end

    // Emit a job at an examined band end or at frame end
    assign eval = info_reg.in_band && info_reg.is_end && (info_reg.band >= cfg.first_band);
    assign push = accept && (eval || last_bin);

    always_comb
    begin
        job.eval          = eval;
        job.last          = last_bin;
        job.band          = info_reg.band;
        job.peak_bin      = peak_bin_next;
        job.sum           = sum_next;
        job.peak          = peak_next;
        job.left          = left_next;
        job.right         = right_next;
        job.energy        = frame_energy;
        job.gain          = band_gain;
        job.trigger_run   = trig_next;
        job.retrigger_run = retrig_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_index_reg <= '0;
            info_reg      <= bin_info('0);
            sum_reg       <= '0;
            peak_reg      <= '0;
            peak_bin_reg  <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            prev_reg      <= '0;
            trig_reg      <= '0;
            retrig_reg    <= '0;
        end
        else if (accept)
        begin
            bin_index_reg <= bin_index_next;
            info_reg      <= info_next;
            prev_reg      <= bin_power;
            trig_reg      <= trig_next;
            retrig_reg    <= retrig_next;
            if (info_reg.in_band)
            begin
                sum_reg      <= sum_next;
                peak_reg     <= peak_next;
                peak_bin_reg <= peak_bin_next;
                left_reg     <= left_next;
                right_reg    <= right_next;
            end
        end
    end

endmodule

// ----- sv/hfd_queue.sv -----
// Short job queue between front and back end.
// Depends on hfd_pkg.
module hfd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hfd_pkg::hfd_job_t push_job,
    input  logic              pop,
    output hfd_pkg::hfd_job_t head_job,
    output logic              empty,
    output logic              full
);
    import hfd_pkg::*;

    hfd_job_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_job = entry_reg[rd_ptr_reg];
    assign do_pop   = pop && !empty;

    // Store pushed jobs
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            if (push && !do_pop)
                count_reg <= count_reg + 3'd1;
            else if (do_pop && !push)
                count_reg <= count_reg - 3'd1;
        end
    end

endmodule

// ----- sv/hfd_back.sv -----
// Back end: sums peak energy, tests band shape, updates per-band counters,
// the hold timer and the result register. Depends on hfd_pkg.
module hfd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hfd_pkg::hfd_cfg_t             cfg,
    input  hfd_pkg::hfd_job_t             head_job,
    input  logic                          empty,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          howl_active,
    output logic                          confirmed,
    output logic [hfd_pkg::HOLD_W-1:0]    hold_left
);
    import hfd_pkg::*;

    // Stage one: peak energy
    logic                s1_valid_reg;
    logic                s1_eval_reg, s1_last_reg;
    logic [BAND_W-1:0]   s1_band_reg;
    logic [BIN_W-1:0]    s1_peak_bin_reg;
    logic [SUM_W-1:0]    s1_sum_reg;
    logic [PEAK3_W-1:0]  s1_peak3_reg;
    logic [ENERGY_W-1:0] s1_energy_reg;
    logic [GAIN_W-1:0]   s1_gain_reg;
    logic [RUN_W-1:0]    s1_trig_reg, s1_retrig_reg;

    // Stage two: shape flags
    logic                s2_valid_reg;
    logic                s2_eval_reg, s2_last_reg;
    logic [BAND_W-1:0]   s2_band_reg;
    logic [BIN_W-1:0]    s2_peak_bin_reg;
    logic                s2_narrow_reg, s2_loud_reg;
    logic [RUN_W-1:0]    s2_trig_reg, s2_retrig_reg;

    // Per-band and frame state
    logic [RUN_W-1:0]    stable_count_reg [NUM_BANDS];
    logic [RUN_W-1:0]    fast_count_reg [NUM_BANDS];
    logic                peak_valid_reg [NUM_BANDS];
    logic [BIN_W-1:0]    peak_bin_reg [NUM_BANDS];
    logic [HOLD_W-1:0]   hold_timer_reg, hold_timer_next;
    logic                frame_trigger_reg;

    logic                out_valid_reg;
    logic                confirmed_reg;
    logic [HOLD_W-1:0]   hold_left_reg;

    logic                adv, commit, frame_end;
    logic [45:0]         sum_x50, sum_x7, peak3_x10, peak3_x5, energy_x2;
    logic [20:0]         gain_x20;
    logic                narrow, loud;

    logic [RUN_W-1:0]    s_cur, f_cur, s_new, f_new, threshold;
    logic [BIN_W-1:0]    lp_bin;
    logic                lp_valid, stable, band_trig, trig_now;

    // Stall only when a frame result cannot enter the output register
    assign adv = !(s2_valid_reg && s2_last_reg && out_valid_reg && !out_ready);
    assign pop = adv && !empty;
    assign commit    = adv && s2_valid_reg;
    assign frame_end = commit && s2_last_reg;

    // Shape tests on exact integer ratios
    always_comb
    begin
        sum_x50   = 46'(s1_sum_reg) * 46'd50;
        sum_x7    = 46'(s1_sum_reg) * 46'd7;
        peak3_x10 = 46'(s1_peak3_reg) * 46'd10;
        peak3_x5  = 46'(s1_peak3_reg) * 46'd5;
        energy_x2 = 46'(s1_energy_reg) * 46'd2;
        gain_x20  = 21'(s1_gain_reg) * 21'd20;
        narrow    = (sum_x50 > 46'(s1_energy_reg)) && (peak3_x10 > sum_x7);
        loud      = (peak3_x5 > energy_x2) && (gain_x20 < 21'd65536);
    end

    // Update the counters of the band being committed
    always_comb
    begin
        s_cur    = stable_count_reg[s2_band_reg];
        f_cur    = fast_count_reg[s2_band_reg];
        lp_valid = peak_valid_reg[s2_band_reg];
        lp_bin   = peak_bin_reg[s2_band_reg];
        stable   = s2_narrow_reg && lp_valid
                   && ({1'b0, s2_peak_bin_reg} <= {1'b0, lp_bin} + 10'd1)
                   && ({1'b0, lp_bin} <= {1'b0, s2_peak_bin_reg} + 10'd1);
        if (stable)
            s_new = (s_cur < cfg.count_cap) ? s_cur + 7'd1 : s_cur;
        else if (s2_narrow_reg)
            s_new = (s_cur > 7'd1) ? s_cur - 7'd1 : '0;
        else
            s_new = (s_cur > 7'd2) ? s_cur - 7'd2 : '0;
        if (stable && s2_loud_reg)
            f_new = (f_cur < cfg.count_cap) ? f_cur + 7'd1 : f_cur;
        else
            f_new = (f_cur > 7'd2) ? f_cur - 7'd2 : '0;
        threshold = (hold_timer_reg != '0) ? s2_retrig_reg : s2_trig_reg;
        band_trig = s2_eval_reg && ((s_new >= threshold) || (f_new >= cfg.fast_run));
        trig_now  = frame_trigger_reg || band_trig;
        if (trig_now)
            hold_timer_next = cfg.hold_frames;
        else if (hold_timer_reg != '0)
            hold_timer_next = hold_timer_reg - 10'd1;
        else
            hold_timer_next = '0;
    end

    // Move payload through the pipeline
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_eval_reg     <= head_job.eval;
            s1_last_reg     <= head_job.last;
            s1_band_reg     <= head_job.band;
            s1_peak_bin_reg <= head_job.peak_bin;
            s1_sum_reg      <= head_job.sum;
            s1_peak3_reg    <= PEAK3_W'(head_job.peak) + PEAK3_W'(head_job.left)
                               + PEAK3_W'(head_job.right);
            s1_energy_reg   <= head_job.energy;
            s1_gain_reg     <= head_job.gain;
            s1_trig_reg     <= head_job.trigger_run;
            s1_retrig_reg   <= head_job.retrigger_run;

            s2_eval_reg     <= s1_eval_reg;
            s2_last_reg     <= s1_last_reg;
            s2_band_reg     <= s1_band_reg;
            s2_peak_bin_reg <= s1_peak_bin_reg;
            s2_narrow_reg   <= narrow;
            s2_loud_reg     <= loud;
            s2_trig_reg     <= s1_trig_reg;
            s2_retrig_reg   <= s1_retrig_reg;
        end
        if (frame_end)
        begin
            confirmed_reg <= trig_now;
            hold_left_reg <= hold_timer_next;
        end
    end

    // Control and detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            hold_timer_reg    <= '0;
            frame_trigger_reg <= 1'b0;
            for (int b = 0; b < NUM_BANDS; b++)
            begin
                stable_count_reg[b] <= '0;
                fast_count_reg[b]   <= '0;
                peak_valid_reg[b]   <= 1'b0;
                peak_bin_reg[b]     <= '0;
            end
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg <= !empty;
                s2_valid_reg <= s1_valid_reg;
            end
            if (commit && s2_eval_reg)
            begin
                stable_count_reg[s2_band_reg] <= s_new;
                fast_count_reg[s2_band_reg]   <= f_new;
                peak_valid_reg[s2_band_reg]   <= s2_narrow_reg;
                peak_bin_reg[s2_band_reg]     <= s2_narrow_reg ? s2_peak_bin_reg : '0;
            end
            if (frame_end)
            begin
                hold_timer_reg    <= hold_timer_next;
                frame_trigger_reg <= 1'b0;
            end
            else if (commit && band_trig)
            begin
                frame_trigger_reg <= 1'b1;
            end
            if (frame_end)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign confirmed   = confirmed_reg;
    assign hold_left   = hold_left_reg;
    assign howl_active = (hold_left_reg != '0);

endmodule

// ----- tb/sv/howling_feedback_detector_core_test.sv -----
// Self-checking testbench for howling_feedback_detector_core: sends FFT bin
// frames and register writes, predicts each frame result and compares it.
// Depends on hfd_pkg and the core RTL only.
`timescale 1ns / 100ps

module howling_feedback_detector_core_test;
    import hfd_pkg::*;

    typedef struct packed {
        logic              howl_active;
        logic              confirmed;
        logic [HOLD_W-1:0] hold_left;
    } frame_result_t;

    localparam int          MAX_FRAME = 600;
    localparam logic [63:0] SUM_MASK  = 64'h00FF_FFFF_FFFF;

    // Frame predictor plus store of expected frame results
    class howl_scoreboard;
        hfd_cfg_t          cfg;
        logic [RUN_W-1:0]  steady_cnt [NUM_BANDS];
        logic [RUN_W-1:0]  squeal_cnt [NUM_BANDS];
        logic [HOLD_W-1:0] peak_hist [NUM_BANDS];
        logic [HOLD_W-1:0] hold_cnt;
        int unsigned       bin_pos;
        int unsigned       peak_at;
        logic [RUN_W-1:0]  run_need;
        logic [63:0]       acc;
        logic [63:0]       peak_pw;
        logic [63:0]       left_pw;
        logic [63:0]       right_pw;
        logic [63:0]       last_pw;
        logic              triggered;
        frame_result_t     pending [$];
        int                errors;

        function new();
            cfg.trigger_run   = RST_TRIGGER_RUN;
            cfg.retrigger_run = RST_RETRIGGER_RUN;
            cfg.hold_frames   = RST_HOLD_FRAMES;
            cfg.fast_run      = RST_FAST_RUN;
            cfg.count_cap     = RST_COUNT_CAP;
            cfg.first_band    = RST_FIRST_BAND;
            for (int b = 0; b < NUM_BANDS; b++)
            begin
                steady_cnt[b] = '0;
                squeal_cnt[b] = '0;
                peak_hist[b]  = '0;
            end
            hold_cnt  = '0;
            bin_pos   = 0;
            peak_at   = 0;
            run_need  = '0;
            acc       = '0;
            peak_pw   = '0;
            left_pw   = '0;
            right_pw  = '0;
            last_pw   = '0;
            triggered = 1'b0;
            errors    = 0;
        endfunction

        function void write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
            case (idx)
                REG_TRIGGER_RUN:   cfg.trigger_run   = value[RUN_W-1:0];
                REG_RETRIGGER_RUN: cfg.retrigger_run = value[RUN_W-1:0];
                REG_HOLD_FRAMES:   cfg.hold_frames   = value[HOLD_W-1:0];
                REG_FAST_RUN:      cfg.fast_run      = value[RUN_W-1:0];
                REG_COUNT_CAP:     cfg.count_cap     = value[RUN_W-1:0];
                REG_FIRST_BAND:    cfg.first_band    = value[BAND_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the detector by one accepted bin transaction
        function void note_bin(input logic [POWER_W-1:0] pw, input logic [ENERGY_W-1:0] fe,
                               input logic [GAIN_W-1:0] gain, input logic lst);
            logic [63:0]   p64;
            logic [63:0]   fe64;
            logic [63:0]   pe;
            logic          narrow;
            logic          steady;
            int unsigned   lo;
            int unsigned   hi;
            int unsigned   lp;
            int            band;
            frame_result_t res;
            p64  = {32'd0, pw};
            fe64 = {22'd0, fe};
            // latch the run threshold from the timer at the start of a frame
            if (bin_pos == 0)
                run_need = (hold_cnt != 0) ? cfg.retrigger_run : cfg.trigger_run;
            band = -1;
            for (int k = 0; k < NUM_BANDS; k++)
                if (bin_pos >= EDGE[k+1] && bin_pos < EDGE[k+2])
                    band = k;
            if (band >= 0)
            begin
                lo = EDGE[band+1];
                hi = EDGE[band+2];
                if (bin_pos == lo)
                begin
                    acc      = '0;
                    peak_pw  = '0;
                    peak_at  = lo;
                    left_pw  = '0;
                    right_pw = '0;
                end
                acc = (acc + p64) & SUM_MASK;
                // first strict maximum wins; track its in-band neighbors
                if (p64 > peak_pw)
                begin
                    peak_pw  = p64;
                    peak_at  = bin_pos;
                    left_pw  = (bin_pos > lo) ? last_pw : 64'd0;
                    right_pw = '0;
                end
                else if (bin_pos == peak_at + 1)
                    right_pw = p64;
                // band end: update run counters and peak history
                if (bin_pos == hi - 1 && band >= int'(cfg.first_band))
                begin
                    pe     = peak_pw + left_pw + right_pw;
                    narrow = (64'd50 * acc > fe64) && (64'd10 * pe > 64'd7 * acc);
                    lp     = peak_hist[band][BIN_W-1:0];
                    steady = narrow && peak_hist[band][BIN_W] &&
                             peak_at <= lp + 1 && lp <= peak_at + 1;
                    if (steady)
                    begin
                        if (steady_cnt[band] < cfg.count_cap)
                            steady_cnt[band] = steady_cnt[band] + 1'b1;
                    end
                    else if (narrow)
                        steady_cnt[band] = (steady_cnt[band] > 1) ? steady_cnt[band] - 1'b1 : '0;
                    else
                        steady_cnt[band] = (steady_cnt[band] > 2) ? steady_cnt[band] - 2'd2 : '0;
                    if (steady && 64'd5 * pe > 64'd2 * fe64 && 64'd20 * {48'd0, gain} < 64'd65536)
                    begin
                        if (squeal_cnt[band] < cfg.count_cap)
                            squeal_cnt[band] = squeal_cnt[band] + 1'b1;
                    end
                    else
                        squeal_cnt[band] = (squeal_cnt[band] > 2) ? squeal_cnt[band] - 2'd2 : '0;
                    peak_hist[band] = narrow ? {1'b1, BIN_W'(peak_at)} : '0;
                    if (steady_cnt[band] >= run_need || squeal_cnt[band] >= cfg.fast_run)
                        triggered = 1'b1;
                end
            end
            last_pw = p64;
            if (!lst)
            begin
                bin_pos = (bin_pos < BIN_MAX) ? bin_pos + 1 : BIN_MAX;
                return;
            end
            // frame end: reload or run down the hold timer
            if (triggered)
                hold_cnt = cfg.hold_frames;
            else if (hold_cnt != 0)
                hold_cnt = hold_cnt - 1'b1;
            res.howl_active = (hold_cnt != 0);
            res.confirmed   = triggered;
            res.hold_left   = hold_cnt;
            pending.push_back(res);
            bin_pos   = 0;
            triggered = 1'b0;
        endfunction

        function void check_result(input frame_result_t got);
            frame_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: result with none expected: active=%0b confirmed=%0b hold_left=%0d",
                         $time, got.howl_active, got.confirmed, got.hold_left);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.howl_active !== want.howl_active)
            begin
                $display("%0t: howl_active expected %0b actual %0b",
                         $time, want.howl_active, got.howl_active);
                errors++;
            end
            if (got.confirmed !== want.confirmed)
            begin
                $display("%0t: confirmed expected %0b actual %0b",
                         $time, want.confirmed, got.confirmed);
                errors++;
            end
            if (got.hold_left !== want.hold_left)
            begin
                $display("%0t: hold_left expected %0d actual %0d",
                         $time, want.hold_left, got.hold_left);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    logic [POWER_W-1:0]  bin_power;
    logic [ENERGY_W-1:0] frame_energy;
    logic [GAIN_W-1:0]   band_gain;
    logic                last_bin;
    logic                out_valid;
    logic                out_ready;
    logic                howl_active;
    logic                confirmed;
    logic [HOLD_W-1:0]   hold_left;

    howl_scoreboard sb = new();

    int          tx_idle_pct;
    int          rx_idle_pct;
    logic        hold_off_req;

    // Frame under construction and the tone scene that persists across frames
    logic [POWER_W-1:0]  fr_pow  [0:MAX_FRAME-1];
    logic [ENERGY_W-1:0] fr_fe   [0:MAX_FRAME-1];
    logic [GAIN_W-1:0]   fr_gain [0:MAX_FRAME-1];
    int                  tone_pos [2];
    logic [POWER_W-1:0]  tone_amp [2];
    int                  scene_age;

    howling_feedback_detector_core u_top (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Check results and feed the predictor at each rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result({howl_active, confirmed, hold_left});
            if (in_valid && in_ready)
                sb.note_bin(bin_power, frame_energy, band_gain, last_bin);
        end
    end

    // Result receiver: random back-pressure, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_off_req = 1'b0;
            end
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Offer one bin transaction; called and returns at a falling edge
    task automatic send_bin(input logic [POWER_W-1:0] pw, input logic [ENERGY_W-1:0] fe,
                            input logic [GAIN_W-1:0] gain, input logic lst);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        bin_power    <= pw;
        frame_energy <= fe;
        band_gain    <= gain;
        last_bin     <= lst;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++)
            send_bin(fr_pow[i], fr_fe[i], fr_gain[i], i == len - 1);
    endtask

    // One register write; leaves psel high so writes can run back to back
    task automatic bus_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        sb.write_reg(idx, value);
    endtask

    // Drain all results, let the pipeline settle, then load every register
    task automatic load_config(input hfd_cfg_t cfg);
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        bus_write(REG_TRIGGER_RUN,   DATA_W'(cfg.trigger_run));
        bus_write(REG_RETRIGGER_RUN, DATA_W'(cfg.retrigger_run));
        bus_write(REG_HOLD_FRAMES,   DATA_W'(cfg.hold_frames));
        bus_write(REG_FAST_RUN,      DATA_W'(cfg.fast_run));
        bus_write(REG_COUNT_CAP,     DATA_W'(cfg.count_cap));
        bus_write(REG_FIRST_BAND,    DATA_W'(cfg.first_band));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Build one frame: background noise plus up to two persistent tones
    task automatic build_frame(input int len, input int tone_lo, input int tone_hi);
        logic [63:0]         total;
        logic [ENERGY_W-1:0] fe;
        int                  bg;
        int                  pick;
        int                  pos;
        logic                no_tone;
        logic                per_bin_fe;
        if (scene_age <= 0 || $urandom_range(0, 9) == 0)
        begin
            for (int t = 0; t < 2; t++)
            begin
                tone_pos[t] = $urandom_range(tone_lo, tone_hi);
                tone_amp[t] = $urandom | 32'h0100_0000;
            end
            scene_age = $urandom_range(4, 12);
        end
        scene_age--;
        // mostly hold the tones still, sometimes drift by a bin or jump
        for (int t = 0; t < 2; t++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 3 && tone_pos[t] < tone_hi)
                tone_pos[t]++;
            else if (pick >= 3 && pick < 6 && tone_pos[t] > tone_lo)
                tone_pos[t]--;
            else if (pick == 6)
                tone_pos[t] = $urandom_range(tone_lo, tone_hi);
        end
        bg         = $urandom_range(0, 9);
        no_tone    = ($urandom_range(0, 19) == 0);
        per_bin_fe = ($urandom_range(0, 19) == 0);
        for (int i = 0; i < len; i++)
        begin
            if (bg < 6)
                fr_pow[i] = $urandom_range(0, 255);
            else if (bg < 8)
                fr_pow[i] = $urandom_range(0, 1 << 20);
            else if (bg == 8)
                fr_pow[i] = '0;
            else
                fr_pow[i] = $urandom;
            pick = $urandom_range(0, 9);
            if (pick < 5)
                fr_gain[i] = $urandom_range(0, 3276);
            else if (pick == 5)
                fr_gain[i] = 16'd3277;
            else
                fr_gain[i] = $urandom_range(0, 65535);
        end
        if (!no_tone)
        begin
            for (int t = 0; t < 2; t++)
            begin
                pos = tone_pos[t];
                if (pos < len)
                begin
                    fr_pow[pos] = tone_amp[t];
                    if (pos > 0 && $urandom_range(0, 1) == 1)
                        fr_pow[pos-1] = tone_amp[t] >> $urandom_range(1, 4);
                    if (pos + 1 < len)
                    begin
                        pick = $urandom_range(0, 7);
                        if (pick == 0)
                            fr_pow[pos+1] = tone_amp[t];
                        else if (pick < 4)
                            fr_pow[pos+1] = tone_amp[t] >> $urandom_range(1, 4);
                    end
                end
            end
        end
        total = '0;
        for (int i = 0; i < len; i++)
            total += {32'd0, fr_pow[i]};
        pick = $urandom_range(0, 9);
        if (pick < 5)
            fe = total[ENERGY_W-1:0];
        else if (pick < 7)
            fe = total[ENERGY_W+1:2];
        else if (pick == 7)
            fe = '0;
        else if (pick == 8)
            fe = '1;
        else
            fe = {10'($urandom_range(0, 1023)), 32'($urandom)};
        for (int i = 0; i < len; i++)
            fr_fe[i] = per_bin_fe ? {10'($urandom_range(0, 1023)), 32'($urandom)} : fe;
    endtask

    // One setting of the registers and of the idle pattern, then random frames
    task automatic run_phase(input hfd_cfg_t cfg, input int len_lo, input int len_hi,
                             input int tone_lo, input int tone_hi, input int budget,
                             input int tx_pct, input int rx_pct, input logic long_stall);
        int sent;
        int len;
        load_config(cfg);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        scene_age   = 0;
        if (long_stall)
            hold_off_req = 1'b1;
        sent = 0;
        while (sent < budget)
        begin
            len = $urandom_range(len_lo, len_hi);
            build_frame(len, tone_lo, tone_hi);
            send_frame(len);
            sent += len;
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        logic [POWER_W-1:0] d_pow  [12];
        logic [GAIN_W-1:0]  d_gain [12];
        d_pow  = '{32'hFFFF_FFFF, 32'd5, 32'd1000, 32'd1000, 32'd0, 32'd0,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd7, 32'd0, 32'd0, 32'h8000_0000};
        d_gain = '{16'hFFFF, 16'd0, 16'd0, 16'd3276, 16'd0, 16'd3277,
                   16'd0, 16'd0, 16'd65535, 16'd65535, 16'd0, 16'd3276};
        clk          = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        bin_power    = '0;
        frame_energy = '0;
        band_gain    = '0;
        last_bin     = 1'b0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_off_req = 1'b0;
        scene_age    = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: lowest bands examined, runs of one confirm at once
        load_config('{trigger_run: 7'd1, retrigger_run: 7'd1, hold_frames: 10'd3,
                      fast_run: 7'd1, count_cap: 7'd127, first_band: 5'd0});
        // single-bin frame: every field at its maximum, no band completes
        fr_pow[0]  = '1;
        fr_fe[0]   = '1;
        fr_gain[0] = '1;
        send_frame(1);
        // two frames, same bins: tied peaks, empty band, full-scale band,
        // gain on both sides of the fast-path limit, so the second is stable
        for (int rep = 0; rep < 2; rep++)
        begin
            for (int i = 0; i < 12; i++)
            begin
                fr_pow[i]  = d_pow[i];
                fr_gain[i] = d_gain[i];
                fr_fe[i]   = (rep == 0) ? 42'd2000 : 42'd3000;
            end
            send_frame(12);
        end
        in_valid <= 1'b0;

        // Random phases: idle pattern rotates, register extremes are visited
        run_phase('{trigger_run: 7'd3, retrigger_run: 7'd2, hold_frames: 10'd5,
                    fast_run: 7'd2, count_cap: 7'd5, first_band: 5'd0},
                  1, 20, 2, 19, 100, 24, 85, 1'b0);
        run_phase('{trigger_run: 7'd1, retrigger_run: 7'd1, hold_frames: 10'd0,
                    fast_run: 7'd100, count_cap: 7'd127, first_band: 5'd2},
                  1, 30, 2, 29, 100, 85, 24, 1'b0);
        run_phase('{trigger_run: 7'd0, retrigger_run: 7'd0, hold_frames: 10'd1023,
                    fast_run: 7'd0, count_cap: 7'd1, first_band: 5'd5},
                  10, 25, 2, 24, 100, 0, 0, 1'b1);
        run_phase('{trigger_run: 7'd100, retrigger_run: 7'd100, hold_frames: 10'd2,
                    fast_run: 7'd1, count_cap: 7'd3, first_band: 5'd0},
                  4, 16, 2, 15, 100, 24, 85, 1'b0);
        run_phase('{trigger_run: RST_TRIGGER_RUN, retrigger_run: RST_RETRIGGER_RUN,
                    hold_frames: RST_HOLD_FRAMES, fast_run: RST_FAST_RUN,
                    count_cap: RST_COUNT_CAP, first_band: RST_FIRST_BAND},
                  24, 40, 21, 39, 140, 85, 24, 1'b0);
        // full-length frames running past the band table and the bin counter
        run_phase('{trigger_run: 7'd1, retrigger_run: 7'd1, hold_frames: 10'd9,
                    fast_run: 7'd1, count_cap: 7'd127, first_band: 5'd31},
                  513, 530, 356, 399, 1000, 0, 0, 1'b0);
        run_phase('{trigger_run: 7'd2, retrigger_run: 7'd1, hold_frames: 10'd6,
                    fast_run: 7'd2, count_cap: 7'd127, first_band: 5'd0},
                  1, 12, 2, 11, 100, 24, 85, 1'b0);

        // Drain and let the pipeline settle before the verdict
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- howling_feedback_detector_core.f -----
sv/hfd_pkg.sv
sv/hfd_front.sv
sv/hfd_queue.sv
sv/hfd_back.sv
sv/howling_feedback_detector_core.sv
tb/sv/howling_feedback_detector_core_test.sv
